FILE: hw/rtl/rwsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsp_pkg
// Types and constants shared by the RIFF WAVE stream parser modules.
// ----------------------------------------------------------------------------
package rwsp_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_FILE_HDR  = 3'd0,
        PH_CHUNK_HDR = 3'd1,
        PH_BODY      = 3'd2,
        PH_PAD       = 3'd3,
        PH_ERROR     = 3'd4
    } phase_t;

    // Kind of chunk whose body is being walked.
    typedef enum logic [1:0] {
        CT_OTHER     = 2'd0,
        CT_FMT       = 2'd1,
        CT_DATA      = 2'd2,
        CT_FMT_SMALL = 2'd3
    } chunk_type_t;

    // Report status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL  = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER = 3'd2;
    localparam logic [2:0] ST_OVERRUN    = 3'd3;
    localparam logic [2:0] ST_FMT_SMALL  = 3'd4;
    localparam logic [2:0] ST_MISSING    = 3'd5;
    localparam logic [2:0] ST_NOT_PCM    = 3'd6;
    localparam logic [2:0] ST_BAD_FORMAT = 3'd7;

    // Beat kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Tags as they appear little-endian in the shift register.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // File positions and sizes.
    localparam logic [5:0]  MIN_FILE_BYTES  = 6'd44;
    localparam logic [5:0]  RIFF_TAG_LAST   = 6'd3;
    localparam logic [5:0]  FILE_HDR_LAST   = 6'd11;
    localparam logic [2:0]  CHUNK_ID_LAST   = 3'd3;
    localparam logic [2:0]  CHUNK_HDR_LAST  = 3'd7;
    localparam logic [31:0] FMT_MIN_BYTES   = 32'd16;
    localparam logic [4:0]  FMT_BODY_BYTES  = 5'd16;

    // Offsets of the last byte of each captured fmt field.
    localparam logic [4:0]  OFF_FORMAT_LAST   = 5'd1;
    localparam logic [4:0]  OFF_CHANNELS_LAST = 5'd3;
    localparam logic [4:0]  OFF_RATE_LAST     = 5'd7;
    localparam logic [4:0]  OFF_BITS_LAST     = 5'd15;

    localparam logic [15:0] FORMAT_PCM = 16'd1;

    // Output queue.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Width of the packed output data word, padded to whole bytes.
    localparam int RES_DATA_BITS = 107;
    localparam int M_TDATA_W     = ((RES_DATA_BITS + 7) / 8) * 8;

    // One result beat.
    typedef struct packed {
        logic        kind;
        logic [7:0]  pcm_byte;
        logic        run_start;
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
        logic        last;
    } res_t;

    // Results produced by the parser for one accepted byte.
    typedef struct packed {
        logic data_valid;
        logic rpt_valid;
    } push_ctl_t;

endpackage

FILE: hw/rtl/rwsp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsp_parse
// Byte-wide parser state: file header check, chunk walk, fmt capture, data
// byte pass-through and the end-of-file report, all updated together for each accepted byte.
// ----------------------------------------------------------------------------
module rwsp_parse
    import rwsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       end_of_file,
    output push_ctl_t  ctl,
    output res_t       data_res,
    output res_t       rpt_res
);

    phase_t      phase_reg,      phase_next;
    logic [5:0]  file_pos_reg,   file_pos_next;
    logic [31:0] hdr_shift_reg,  hdr_shift_next;
    logic [2:0]  field_idx_reg,  field_idx_next;
    logic [31:0] chunk_len_reg,  chunk_len_next;
    logic [31:0] chunk_left_reg, chunk_left_next;
    chunk_type_t chunk_type_reg, chunk_type_next;
    logic [4:0]  body_off_reg,   body_off_next;
    logic        seen_fmt_reg,   seen_fmt_next;
    logic        seen_data_reg,  seen_data_next;
    logic [15:0] format_reg,     format_next;
    logic [15:0] channels_reg,   channels_next;
    logic [31:0] rate_reg,       rate_next;
    logic [15:0] bits_reg,       bits_next;
    logic [31:0] data_size_reg,  data_size_next;
    logic [2:0]  error_reg,      error_next;

    logic [31:0] shift_in;
    logic [31:0] len_shift;
    logic [31:0] left_dec;
    chunk_type_t new_type;
    logic        done_now;
    chunk_type_t done_type;
    logic        done_odd;
    logic [2:0]  status;
    logic        full_report;

    assign shift_in  = {in_byte, hdr_shift_reg[31:8]};
    assign len_shift = {in_byte, chunk_len_reg[31:8]};
    assign left_dec  = chunk_left_reg - 32'd1;

    // Next state and results for the accepted byte.
    always_comb
    begin
        phase_next      = phase_reg;
        file_pos_next   = file_pos_reg;
        hdr_shift_next  = hdr_shift_reg;
        field_idx_next  = field_idx_reg;
        chunk_len_next  = chunk_len_reg;
        chunk_left_next = chunk_left_reg;
        chunk_type_next = chunk_type_reg;
        body_off_next   = body_off_reg;
        seen_fmt_next   = seen_fmt_reg;
        seen_data_next  = seen_data_reg;
        format_next     = format_reg;
        channels_next   = channels_reg;
        rate_next       = rate_reg;
        bits_next       = bits_reg;
        data_size_next  = data_size_reg;
        error_next      = error_reg;
        new_type        = chunk_type_reg;
        done_now        = 1'b0;
        done_type       = chunk_type_reg;
        done_odd        = chunk_len_reg[0];
        status          = ST_OK;
        full_report     = 1'b0;
        ctl             = '0;
        data_res        = '0;
        rpt_res         = '0;

        if (step)
        begin
            if (file_pos_reg < MIN_FILE_BYTES)
            begin
                file_pos_next = file_pos_reg + 6'd1;
            end

            unique case (phase_reg)
                PH_FILE_HDR:
                begin
                    hdr_shift_next = shift_in;
                    if (file_pos_reg == RIFF_TAG_LAST && shift_in != TAG_RIFF)
                    begin
                        error_next = ST_BAD_HEADER;
                        phase_next = PH_ERROR;
                    end
                    else if (file_pos_reg == FILE_HDR_LAST)
                    begin
                        if (shift_in != TAG_WAVE)
                        begin
                            error_next = ST_BAD_HEADER;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            phase_next     = PH_CHUNK_HDR;
                            field_idx_next = '0;
                        end
                    end
                end

                PH_CHUNK_HDR:
                begin
                    // Four id bytes, then four length bytes.
                    if (field_idx_reg <= CHUNK_ID_LAST)
                    begin
                        hdr_shift_next = shift_in;
                        if (field_idx_reg == CHUNK_ID_LAST)
                        begin
                            if (shift_in == TAG_FMT)
                            begin
                                chunk_type_next = CT_FMT;
                            end
                            else if (shift_in == TAG_DATA)
                            begin
                                chunk_type_next = CT_DATA;
                            end
                            else
                            begin
                                chunk_type_next = CT_OTHER;
                            end
                        end
                    end
                    else
                    begin
                        chunk_len_next = len_shift;
                    end

                    if (field_idx_reg == CHUNK_HDR_LAST)
                    begin
                        chunk_left_next = len_shift;
                        body_off_next   = '0;
                        if (chunk_type_reg == CT_FMT)
                        begin
                            if (len_shift < FMT_MIN_BYTES)
                            begin
                                new_type = CT_FMT_SMALL;
                            end
                            else
                            begin
                                seen_fmt_next = 1'b1;
                            end
                        end
                        else if (chunk_type_reg == CT_DATA)
                        begin
                            seen_data_next = 1'b1;
                            data_size_next = len_shift;
                        end
                        chunk_type_next = new_type;
                        phase_next      = PH_BODY;
                        done_now        = (len_shift == 32'd0);
                        done_type       = new_type;
                        done_odd        = len_shift[0];
                    end
                    else
                    begin
                        field_idx_next = field_idx_reg + 3'd1;
                    end
                end

                PH_BODY:
                begin
                    if (chunk_type_reg == CT_FMT && body_off_reg < FMT_BODY_BYTES)
                    begin
                        hdr_shift_next = shift_in;
                        if (body_off_reg == OFF_FORMAT_LAST)
                        begin
                            format_next = shift_in[31:16];
                        end
                        else if (body_off_reg == OFF_CHANNELS_LAST)
                        begin
                            channels_next = shift_in[31:16];
                        end
                        else if (body_off_reg == OFF_RATE_LAST)
                        begin
                            rate_next = shift_in;
                        end
                        else if (body_off_reg == OFF_BITS_LAST)
                        begin
                            bits_next = shift_in[31:16];
                        end
                    end
                    else if (chunk_type_reg == CT_DATA)
                    begin
                        ctl.data_valid     = 1'b1;
                        data_res.kind      = KIND_DATA;
                        data_res.pcm_byte  = in_byte;
                        data_res.run_start = (chunk_left_reg == chunk_len_reg);
                    end

                    if (body_off_reg < FMT_BODY_BYTES)
                    begin
                        body_off_next = body_off_reg + 5'd1;
                    end
                    chunk_left_next = left_dec;
                    done_now        = (left_dec == 32'd0);
                end

                PH_PAD:
                begin
                    phase_next     = PH_CHUNK_HDR;
                    field_idx_next = '0;
                end

                PH_ERROR:
                begin
                    // Remaining bytes are only counted.
                end

                default:
                begin
                end
            endcase

            // End of a chunk body.
            if (done_now)
            begin
                if (done_type == CT_FMT_SMALL)
                begin
                    error_next = ST_FMT_SMALL;
                    phase_next = PH_ERROR;
                end
                else if (done_odd)
                begin
                    phase_next = PH_PAD;
                end
                else
                begin
                    phase_next     = PH_CHUNK_HDR;
                    field_idx_next = '0;
                end
            end

            // End-of-file report, then back to the reset state.
            if (end_of_file)
            begin
                priority if (file_pos_next < MIN_FILE_BYTES)
                begin
                    status = ST_TOO_SMALL;
                end
                else if (error_next != ST_OK)
                begin
                    status = error_next;
                end
                else if (phase_next == PH_BODY)
                begin
                    status = ST_OVERRUN;
                end
                else if (!seen_fmt_next || !seen_data_next)
                begin
                    status = ST_MISSING;
                end
                else if (format_next != FORMAT_PCM)
                begin
                    status = ST_NOT_PCM;
                end
                else if (channels_next == 16'd0 || rate_next == 32'd0 ||
                         bits_next == 16'd0)
                begin
                    status = ST_BAD_FORMAT;
                end
                else
                begin
                    status = ST_OK;
                end

                full_report = (status == ST_OK) || (status == ST_NOT_PCM) ||
                              (status == ST_BAD_FORMAT);

                ctl.rpt_valid  = 1'b1;
                rpt_res.kind   = KIND_REPORT;
                rpt_res.status = status;
                rpt_res.last   = 1'b1;
                if (full_report)
                begin
                    rpt_res.channel_count = channels_next;
                    rpt_res.sample_rate   = rate_next;
                    rpt_res.sample_bits   = bits_next;
                    rpt_res.data_length   = data_size_next;
                end

                phase_next      = PH_FILE_HDR;
                file_pos_next   = '0;
                hdr_shift_next  = '0;
                field_idx_next  = '0;
                chunk_len_next  = '0;
                chunk_left_next = '0;
                chunk_type_next = CT_OTHER;
                body_off_next   = '0;
                seen_fmt_next   = 1'b0;
                seen_data_next  = 1'b0;
                format_next     = '0;
                channels_next   = '0;
                rate_next       = '0;
                bits_next       = '0;
                data_size_next  = '0;
                error_next      = ST_OK;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FILE_HDR;
            file_pos_reg   <= '0;
            hdr_shift_reg  <= '0;
            field_idx_reg  <= '0;
            chunk_len_reg  <= '0;
            chunk_left_reg <= '0;
            chunk_type_reg <= CT_OTHER;
            body_off_reg   <= '0;
            seen_fmt_reg   <= 1'b0;
            seen_data_reg  <= 1'b0;
            format_reg     <= '0;
            channels_reg   <= '0;
            rate_reg       <= '0;
            bits_reg       <= '0;
            data_size_reg  <= '0;
            error_reg      <= ST_OK;
        end
        else
        begin
            phase_reg      <= phase_next;
            file_pos_reg   <= file_pos_next;
            hdr_shift_reg  <= hdr_shift_next;
            field_idx_reg  <= field_idx_next;
            chunk_len_reg  <= chunk_len_next;
            chunk_left_reg <= chunk_left_next;
            chunk_type_reg <= chunk_type_next;
            body_off_reg   <= body_off_next;
            seen_fmt_reg   <= seen_fmt_next;
            seen_data_reg  <= seen_data_next;
            format_reg     <= format_next;
            channels_reg   <= channels_next;
            rate_reg       <= rate_next;
            bits_reg       <= bits_next;
            data_size_reg  <= data_size_next;
            error_reg      <= error_next;
        end
    end

    // A data beat only comes out of a data chunk body.
    a_data_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.data_valid |-> (phase_reg == PH_BODY && chunk_type_reg == CT_DATA))
        else $error("data beat outside a data chunk body");

    // The report leaves the parser ready for a new file.
    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_of_file) |=>
            (phase_reg == PH_FILE_HDR && file_pos_reg == 6'd0 && error_reg == ST_OK))
        else $error("parser not back at file start after report");

endmodule

FILE: hw/rtl/rwsp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsp_outq
// Small result queue: takes up to two beats per cycle from the parser and
// hands one beat per cycle to the output side while out_ready is high.
// ----------------------------------------------------------------------------
module rwsp_outq
    import rwsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_ctl_t ctl,
    input  res_t      data_res,
    input  res_t      rpt_res,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output res_t      out_res
);

    res_t             entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg,  count_next;

    logic             a_valid;
    logic             b_valid;
    res_t             a_res;
    logic [QAW-1:0]   wr_ptr_b;
    logic             pop;
    logic [QCW-1:0]   n_push;

    // The data beat goes first when both come from one byte.
    assign a_valid  = ctl.data_valid | ctl.rpt_valid;
    assign b_valid  = ctl.data_valid & ctl.rpt_valid;
    assign a_res    = ctl.data_valid ? data_res : rpt_res;
    assign wr_ptr_b = wr_ptr_reg + {{(QAW-1){1'b0}}, 1'b1};

    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;
    assign room      = (count_reg <= QCW'(QDEPTH - 2));

    // Pointer and fill bookkeeping.
    always_comb
    begin
        n_push      = QCW'(a_valid) + QCW'(b_valid);
        wr_ptr_next = wr_ptr_reg + n_push[QAW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(QAW-1){1'b0}}, pop};
        count_next  = count_reg + n_push - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; no reset needed.
    always_ff @(posedge clk)
    begin
        if (a_valid)
        begin
            entry_reg[wr_ptr_reg] <= a_res;
        end
        if (b_valid)
        begin
            entry_reg[wr_ptr_b] <= rpt_res;
        end
    end

    // The fill level never passes the queue depth.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("result queue overflow");

    // The parser only produces beats when two free slots were promised.
    a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid |-> room)
        else $error("result pushed without room");

endmodule

FILE: hw/rtl/riff_wave_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_wave_stream_parser_top
// RIFF WAVE byte-stream parser with data pass-through and end-of-file report.
// ----------------------------------------------------------------------------
// The block takes one file byte per beat and can accept a byte every cycle:
// each byte updates the parser state and its results enter a four-beat
// output queue. A data-chunk byte gives one output beat; the final byte
// (tlast) gives the report, and when it is also a data byte it gives two
// beats, data first. Input is taken whenever at least two queue slots are
// free, so a stalled consumer holds the input back once fewer than two are
// free. After the report all state is cleared and the next byte starts a
// new file.
module riff_wave_stream_parser_top
    import rwsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] in_byte
    input  logic                 s_tlast,   // end_of_file
    // Output stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] pcm_byte, [10:8] status, [26:11] channel_count,
    // [58:27] sample_rate, [74:59] sample_bits, [106:75] data_length,
    // [111:107] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser,   // [0] kind, [1] run_start
    output logic                 m_tlast    // last
);

    push_ctl_t ctl;
    res_t      data_res;
    res_t      rpt_res;
    res_t      out_res;
    logic      room;
    logic      step;

    assign s_tready = room;
    assign step     = s_tvalid & room;

    rwsp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .in_byte     (s_tdata),
        .end_of_file (s_tlast),
        .ctl         (ctl),
        .data_res    (data_res),
        .rpt_res     (rpt_res)
    );

    rwsp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .data_res  (data_res),
        .rpt_res   (rpt_res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result beat onto the output bus.
    assign m_tdata = {{(M_TDATA_W - RES_DATA_BITS){1'b0}},
                      out_res.data_length,
                      out_res.sample_bits,
                      out_res.sample_rate,
                      out_res.channel_count,
                      out_res.status,
                      out_res.pcm_byte};
    assign m_tuser = {out_res.run_start, out_res.kind};
    assign m_tlast = out_res.last;

endmodule

FILE: dv/tb_riff_wave_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_riff_wave_stream_parser_top
// Self-checking bench for the RIFF WAVE stream parser.
// ----------------------------------------------------------------------------
// Whole WAVE files are built byte by byte and queued for a clocked driver.
// First come hand-made files for each status and corner case, then random
// files. Most random files are well formed, with random chunk order, sizes
// and field values; the rest carry broken tags, short or truncated chunks,
// trailing bytes or plain noise. A parser model runs on every byte the block
// accepts and queues the data beats and the report that should follow. A
// clocked monitor checks every output beat, field by field, against the
// oldest queued beat. Both sides idle at random, with calm stretches between.
module tb_riff_wave_stream_parser_top;
    import rwsp_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 20;
    localparam int BYTE_TARGET = 2000;

    typedef struct {
        logic [7:0] data;
        logic       eof;
    } file_byte_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'd0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    riff_wave_stream_parser_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    file_byte_t pending_bytes[$];
    logic [7:0] file_buf[$];
    res_t       expected_beats[$];

    int mismatches  = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int stall_left  = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    // Parser model state.
    phase_t      ph;
    logic [5:0]  fpos;
    logic [31:0] shreg;
    logic [2:0]  fidx;
    logic [31:0] clen;
    logic [31:0] cleft;
    chunk_type_t ctype;
    logic [4:0]  boff;
    bit          seen_fmt;
    bit          seen_data;
    logic [15:0] fcode;
    logic [15:0] ch_held;
    logic [31:0] rate_held;
    logic [15:0] bits_held;
    logic [31:0] dlen_held;
    logic [2:0]  err;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        ph        = PH_FILE_HDR;
        fpos      = '0;
        shreg     = '0;
        fidx      = '0;
        clen      = '0;
        cleft     = '0;
        ctype     = CT_OTHER;
        boff      = '0;
        seen_fmt  = 1'b0;
        seen_data = 1'b0;
        fcode     = '0;
        ch_held   = '0;
        rate_held = '0;
        bits_held = '0;
        dlen_held = '0;
        err       = ST_OK;
    endfunction

    // A chunk body has been fully consumed.
    function automatic void close_body();
        if (ctype == CT_FMT_SMALL)
        begin
            err = ST_FMT_SMALL;
            ph  = PH_ERROR;
        end
        else if (clen[0])
        begin
            ph = PH_PAD;
        end
        else
        begin
            ph   = PH_CHUNK_HDR;
            fidx = '0;
        end
    endfunction

    // Advance the model by one file byte and queue the beats it yields.
    function automatic void parse_byte(logic [7:0] b, logic eof);
        logic [5:0] pos;
        logic [2:0] st;
        res_t       r;
        pos = fpos;
        if (fpos < MIN_FILE_BYTES)
            fpos++;
        case (ph)
            PH_FILE_HDR:
            begin
                shreg = {b, shreg[31:8]};
                if (pos == RIFF_TAG_LAST && shreg != TAG_RIFF)
                begin
                    err = ST_BAD_HEADER;
                    ph  = PH_ERROR;
                end
                else if (pos == FILE_HDR_LAST)
                begin
                    if (shreg != TAG_WAVE)
                    begin
                        err = ST_BAD_HEADER;
                        ph  = PH_ERROR;
                    end
                    else
                    begin
                        ph   = PH_CHUNK_HDR;
                        fidx = '0;
                    end
                end
            end
            PH_CHUNK_HDR:
            begin
                if (fidx <= CHUNK_ID_LAST)
                begin
                    shreg = {b, shreg[31:8]};
                    if (fidx == CHUNK_ID_LAST)
                    begin
                        if (shreg == TAG_FMT)
                            ctype = CT_FMT;
                        else if (shreg == TAG_DATA)
                            ctype = CT_DATA;
                        else
                            ctype = CT_OTHER;
                    end
                end
                else
                begin
                    clen = {b, clen[31:8]};
                end
                if (fidx >= CHUNK_HDR_LAST)
                begin
                    cleft = clen;
                    boff  = '0;
                    if (ctype == CT_FMT)
                    begin
                        if (clen < FMT_MIN_BYTES)
                            ctype = CT_FMT_SMALL;
                        else
                            seen_fmt = 1'b1;
                    end
                    else if (ctype == CT_DATA)
                    begin
                        seen_data = 1'b1;
                        dlen_held = clen;
                    end
                    ph = PH_BODY;
                    if (cleft == 32'd0)
                        close_body();
                end
                else
                begin
                    fidx++;
                end
            end
            PH_BODY:
            begin
                if (ctype == CT_FMT && boff < FMT_BODY_BYTES)
                begin
                    shreg = {b, shreg[31:8]};
                    case (boff)
                        OFF_FORMAT_LAST:   fcode     = shreg[31:16];
                        OFF_CHANNELS_LAST: ch_held   = shreg[31:16];
                        OFF_RATE_LAST:     rate_held = shreg;
                        OFF_BITS_LAST:     bits_held = shreg[31:16];
                        default: ;
                    endcase
                end
                else if (ctype == CT_DATA)
                begin
                    r           = '0;
                    r.kind      = KIND_DATA;
                    r.pcm_byte  = b;
                    r.run_start = (cleft == clen);
                    expected_beats.insert(expected_beats.size(), r);
                end
                if (boff < FMT_BODY_BYTES)
                    boff++;
                cleft--;
                if (cleft == 32'd0)
                    close_body();
            end
            PH_PAD:
            begin
                ph   = PH_CHUNK_HDR;
                fidx = '0;
            end
            default: ;
        endcase

        // End of file: work out the status by priority and queue the report.
        if (eof)
        begin
            if (fpos < MIN_FILE_BYTES)
                st = ST_TOO_SMALL;
            else if (err != ST_OK)
                st = err;
            else if (ph == PH_BODY)
                st = ST_OVERRUN;
            else if (!seen_fmt || !seen_data)
                st = ST_MISSING;
            else if (fcode != FORMAT_PCM)
                st = ST_NOT_PCM;
            else if (ch_held == 16'd0 || rate_held == 32'd0 || bits_held == 16'd0)
                st = ST_BAD_FORMAT;
            else
                st = ST_OK;
            r        = '0;
            r.kind   = KIND_REPORT;
            r.status = st;
            r.last   = 1'b1;
            if (st == ST_OK || st == ST_NOT_PCM || st == ST_BAD_FORMAT)
            begin
                r.channel_count = ch_held;
                r.sample_rate   = rate_held;
                r.sample_bits   = bits_held;
                r.data_length   = dlen_held;
            end
            expected_beats.insert(expected_beats.size(), r);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------
    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_buf.insert(file_buf.size(), v[8*i +: 8]);
    endfunction

    function automatic void put_rand(int n);
        for (int i = 0; i < n; i++)
            file_buf.insert(file_buf.size(), 8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_file_hdr();
        put_le(TAG_RIFF, 4);
        put_rand(4);
        put_le(TAG_WAVE, 4);
    endfunction

    // A chunk with random body bytes and a pad byte after an odd body.
    function automatic void put_plain(logic [31:0] tag, logic [31:0] len);
        put_le(tag, 4);
        put_le(len, 4);
        put_rand(len);
        if (len[0])
            put_rand(1);
    endfunction

    // The low bytes of code, ch and bits give the 16-bit fields.
    function automatic void put_fmt(logic [31:0] len, logic [31:0] code,
                                    logic [31:0] ch, logic [31:0] rate,
                                    logic [31:0] bits);
        put_le(TAG_FMT, 4);
        put_le(len, 4);
        if (len >= FMT_MIN_BYTES)
        begin
            put_le(code, 2);
            put_le(ch, 2);
            put_le(rate, 4);
            put_rand(6);
            put_le(bits, 2);
            put_rand(len - FMT_MIN_BYTES);
        end
        else
        begin
            put_rand(len);
        end
        if (len[0])
            put_rand(1);
    endfunction

    // Move the file under construction into the send queue.
    function automatic void commit_file();
        file_byte_t fb;
        foreach (file_buf[i])
        begin
            fb.data = file_buf[i];
            fb.eof  = (i == file_buf.size() - 1);
            pending_bytes.insert(pending_bytes.size(), fb);
        end
        file_buf.delete();
    endfunction

    function automatic logic [31:0] pick_field(int zero_pct, int wide_pct,
                                               logic [31:0] usual);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return '0;
        if (r < zero_pct + wide_pct)
            return $urandom;
        return usual;
    endfunction

    function automatic void put_random_fmt();
        int          r;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = FMT_MIN_BYTES;
        else if (r < 85)
            len = $urandom_range(17, 22);
        else
            len = $urandom_range(0, 15);
        put_fmt(len,
                pick_field(0, 15, 32'(FORMAT_PCM)),
                pick_field(8, 5, $urandom_range(1, 8)),
                pick_field(8, 10, $urandom_range(8000, 192000)),
                pick_field(8, 7, 8 * $urandom_range(1, 4)));
    endfunction

    function automatic void put_random_chunk();
        case ($urandom_range(0, 2))
            0:       put_random_fmt();
            1:       put_plain(TAG_DATA, $urandom_range(0, 14));
            default: put_plain($urandom, $urandom_range(0, 8));
        endcase
    endfunction

    function automatic void random_file();
        int         r;
        int         idx;
        int         cut;
        logic [7:0] flip;
        // Plain noise now and then.
        if ($urandom_range(0, 99) < 5)
        begin
            put_rand($urandom_range(1, 60));
            commit_file();
            return;
        end
        put_file_hdr();
        if ($urandom_range(0, 99) < 5)
        begin
            idx = $urandom_range(0, 7);
            if (idx >= 4)
                idx += 4;
            flip = 8'($urandom_range(1, 255));
            file_buf[idx] = file_buf[idx] ^ flip;
        end
        if ($urandom_range(0, 99) < 80)
        begin
            put_random_fmt();
            put_plain(TAG_DATA, $urandom_range(0, 40));
            repeat ($urandom_range(0, 3)) put_random_chunk();
        end
        else
        begin
            repeat ($urandom_range(1, 5)) put_random_chunk();
        end
        // Vary the ending.
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            put_rand($urandom_range(1, 7));
        end
        else if (r < 25)
        begin
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut)
                void'(file_buf.pop_back());
        end
        else if (r < 30)
        begin
            put_le(TAG_DATA, 4);
            put_le($urandom | 32'h0000_0100, 4);
            put_rand($urandom_range(1, 10));
        end
        commit_file();
    endfunction

    task automatic directed_files();
        // Single-byte file.
        put_rand(1);
        commit_file();
        // Broken RIFF tag.
        put_le(TAG_RIFF ^ 32'h0100_0000, 4);
        put_rand(46);
        commit_file();
        // Broken WAVE tag.
        put_le(TAG_RIFF, 4);
        put_rand(4);
        put_le(TAG_WAVE ^ 32'h0000_2000, 4);
        put_rand(40);
        commit_file();
        // Well-formed PCM file.
        put_file_hdr();
        put_fmt(16, 32'(FORMAT_PCM), 2, 44100, 16);
        put_plain(TAG_DATA, 4);
        commit_file();
        // Short fmt chunk received in full.
        put_file_hdr();
        put_fmt(14, 32'(FORMAT_PCM), 1, 8000, 8);
        put_plain(TAG_DATA, 8);
        commit_file();
        // Short fmt chunk cut off by the end of file.
        put_file_hdr();
        put_plain(32'h4B4E_554A, 20);
        put_le(TAG_FMT, 4);
        put_le(12, 4);
        put_rand(6);
        commit_file();
        // No data chunk.
        put_file_hdr();
        put_fmt(16, 32'(FORMAT_PCM), 2, 48000, 24);
        put_plain(32'h5453_494C, 10);
        commit_file();
        // Format code other than PCM.
        put_file_hdr();
        put_fmt(16, 32'd3, 2, 48000, 32);
        put_plain(TAG_DATA, 2);
        commit_file();
        // Zero channel count.
        put_file_hdr();
        put_fmt(16, 32'(FORMAT_PCM), 0, 22050, 16);
        put_plain(TAG_DATA, 2);
        commit_file();
        // Partial chunk header after the last chunk.
        put_file_hdr();
        put_fmt(16, 32'(FORMAT_PCM), 1, 11025, 8);
        put_plain(TAG_DATA, 6);
        put_rand(5);
        commit_file();
        // Odd data chunk at the end with its pad byte missing.
        put_file_hdr();
        put_fmt(16, 32'(FORMAT_PCM), 1, 16000, 16);
        put_le(TAG_DATA, 4);
        put_le(3, 4);
        put_rand(3);
        commit_file();
        // Two fmt chunks, the second odd and at the field maxima, then an
        // empty data chunk last.
        put_file_hdr();
        put_fmt(18, 32'(FORMAT_PCM), 1, 8000, 8);
        put_plain(TAG_DATA, 3);
        put_fmt(17, 32'(FORMAT_PCM), 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
        put_plain(TAG_DATA, 0);
        commit_file();
        // Huge data chunk that the file cuts off.
        put_file_hdr();
        put_fmt(16, 32'(FORMAT_PCM), 2, 96000, 24);
        put_le(TAG_DATA, 4);
        put_le(32'hFFFF_FFF0, 4);
        put_rand(10);
        commit_file();
        // Empty fmt chunk.
        put_file_hdr();
        put_fmt(0, 32'(FORMAT_PCM), 0, 0, 0);
        put_rand(30);
        commit_file();
        // Short file that also has a broken tag.
        put_le(TAG_RIFF ^ 32'h0000_0080, 4);
        put_rand(10);
        commit_file();
    endtask

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one file byte per beat, random gaps between beats.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        file_byte_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.eof;
                    if (!send_steady && $urandom_range(0, 99) < 30)
                        send_gap = idle_len();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            if ($urandom_range(0, 99) == 0)
                send_steady = !send_steady;
        end
    end

    // ------------------------------------------------------------------
    // Output back-pressure.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!recv_steady && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_len() - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
            if ($urandom_range(0, 99) == 0)
                recv_steady = !recv_steady;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t seen;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.kind          = m_tuser[0];
            seen.run_start     = m_tuser[1];
            seen.pcm_byte      = m_tdata[7:0];
            seen.status        = m_tdata[10:8];
            seen.channel_count = m_tdata[26:11];
            seen.sample_rate   = m_tdata[58:27];
            seen.sample_bits   = m_tdata[74:59];
            seen.data_length   = m_tdata[106:75];
            seen.last          = m_tlast;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got tuser %0h tdata %0h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("kind", 32'(want.kind), 32'(seen.kind));
                check_field("pcm_byte", 32'(want.pcm_byte), 32'(seen.pcm_byte));
                check_field("run_start", 32'(want.run_start), 32'(seen.run_start));
                check_field("status", 32'(want.status), 32'(seen.status));
                check_field("channel_count", 32'(want.channel_count),
                            32'(seen.channel_count));
                check_field("sample_rate", want.sample_rate, seen.sample_rate);
                check_field("sample_bits", 32'(want.sample_bits),
                            32'(seen.sample_bits));
                check_field("data_length", want.data_length, seen.data_length);
                check_field("last", 32'(want.last), 32'(seen.last));
            end
            if (m_tdata[M_TDATA_W-1:RES_DATA_BITS] !== '0)
            begin
                $display("%0t: tdata padding mismatch, expected 0, got %0h",
                         $time, m_tdata[M_TDATA_W-1:RES_DATA_BITS]);
                mismatches++;
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        clear_parser();
        directed_files();
        while (pending_bytes.size() < BYTE_TARGET)
            random_file();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
